/* src/button_gesture_classifier_assert.svh */
// Assertion macros shared by the gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bgc_pkg.sv */
// Types and codes for the button gesture classifier.
package bgc_pkg;

  localparam int unsigned CFG_W  = 20;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned EV_W   = 3;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_MEDIUM   = 2'd1,
    CFG_LONG     = 2'd2,
    CFG_DOUBLE   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_REL_WAIT = 2'd2,
    PH_SECOND   = 2'd3
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_MEDIUM = 3'd3,
    EV_LONG   = 3'd4
  } gesture_event_t;

  typedef struct packed {
    logic              button_level;
    logic [TIME_W-1:0] time_now;
  } in_beat_t;

  typedef struct packed {
    logic [EV_W-1:0] gesture_event;
    logic            held_flag;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] medium_hold_ms;
    logic [CFG_W-1:0] long_hold_ms;
    logic [CFG_W-1:0] double_click_ms;
  } cfg_t;

endpackage

/* src/bgc_cfg_regs.sv */
// Timing configuration registers of the gesture classifier.
module bgc_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_addr,
  input  logic [bgc_pkg::CFG_W-1:0] cfg_wdata,
  output bgc_pkg::cfg_t           cfg
);
  import bgc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_addr))
        CFG_DEBOUNCE: cfg_nxt.debounce_ms     = cfg_wdata;
        CFG_MEDIUM:   cfg_nxt.medium_hold_ms  = cfg_wdata;
        CFG_LONG:     cfg_nxt.long_hold_ms    = cfg_wdata;
        CFG_DOUBLE:   cfg_nxt.double_click_ms = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= CFG_W'(50);
      cfg_r.medium_hold_ms  <= CFG_W'(2000);
      cfg_r.long_hold_ms    <= CFG_W'(10000);
      cfg_r.double_click_ms <= CFG_W'(300);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/bgc_fsm.sv */
// Gesture state machine: phase, press/release times and held flag.
`include "button_gesture_classifier_assert.svh"
module bgc_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  bgc_pkg::in_beat_t   poll,
  input  bgc_pkg::cfg_t       cfg,
  output bgc_pkg::out_beat_t  result
);
  import bgc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] press_time_r, press_time_nxt;
  logic [TIME_W-1:0] release_time_r, release_time_nxt;
  logic              held_r, held_nxt;
  gesture_event_t    ev;

  logic [TIME_W-1:0] d_ms, r_ms;
  logic              d_gt_long, d_gt_medium, d_lt_long, d_gt_deb, r_lt_dbl;

  // elapsed times wrap modulo 2^32
  assign d_ms = poll.time_now - press_time_r;
  assign r_ms = poll.time_now - release_time_r;

  assign d_gt_long   = d_ms > TIME_W'(cfg.long_hold_ms);
  assign d_lt_long   = d_ms < TIME_W'(cfg.long_hold_ms);
  assign d_gt_medium = d_ms > TIME_W'(cfg.medium_hold_ms);
  assign d_gt_deb    = d_ms > TIME_W'(cfg.debounce_ms);
  assign r_lt_dbl    = r_ms < TIME_W'(cfg.double_click_ms);

  always_comb begin
    phase_nxt        = phase_r;
    press_time_nxt   = press_time_r;
    release_time_nxt = release_time_r;
    held_nxt         = held_r;
    ev               = EV_NONE;
    unique case (phase_r)
      PH_IDLE: begin
        if (poll.button_level) begin
          press_time_nxt = poll.time_now;
          phase_nxt      = PH_PRESSED;
          held_nxt       = 1'b1;
        end
      end
      PH_PRESSED: begin
        priority if (poll.button_level && d_gt_long) begin
          ev        = EV_LONG;
          phase_nxt = PH_IDLE;
          held_nxt  = 1'b0;
        end else if (poll.button_level && d_gt_medium && d_lt_long) begin
          ev = EV_MEDIUM;
        end else if (!poll.button_level && d_gt_deb) begin
          release_time_nxt = poll.time_now;
          phase_nxt        = PH_REL_WAIT;
          held_nxt         = 1'b0;
        end else begin
          // held without a medium or long event, or released inside debounce
          ev = EV_NONE;
        end
      end
      PH_REL_WAIT: begin
        priority if (poll.button_level && r_lt_dbl) begin
          phase_nxt = PH_SECOND;
          held_nxt  = 1'b1;
        end else if (!r_lt_dbl) begin
          ev        = EV_CLICK;
          phase_nxt = PH_IDLE;
        end else begin
          // still released inside the window
          ev = EV_NONE;
        end
      end
      PH_SECOND: begin
        // release debounced against the first press time
        if (!poll.button_level && d_gt_deb) begin
          ev        = EV_DOUBLE;
          phase_nxt = PH_IDLE;
          held_nxt  = 1'b0;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      press_time_r   <= '0;
      release_time_r <= '0;
      held_r         <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      press_time_r   <= press_time_nxt;
      release_time_r <= release_time_nxt;
      held_r         <= held_nxt;
    end
  end

  assign result.gesture_event = ev;
  assign result.held_flag     = held_nxt;

  `BGC_ASSERT_NOW(a_held_tracks_phase, 1'b1,
    held_r == ((phase_r == PH_PRESSED) || (phase_r == PH_SECOND)),
    "held flag out of step with phase")
  `BGC_ASSERT_NEXT(a_long_to_idle, step && (ev == EV_LONG), phase_r == PH_IDLE,
    "long hold did not return to idle")
  `BGC_ASSERT_NOW(a_double_from_second, step && (ev == EV_DOUBLE),
    $past(phase_r) == PH_SECOND || phase_r == PH_SECOND,
    "double click outside second press")

endmodule

/* src/button_gesture_classifier.sv */
// Top level of the push-button gesture classifier.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one poll per beat: the
//   button level and a free-running 32-bit millisecond timestamp.
//   Output channel out_valid/out_stall/out_data returns exactly one beat per
//   poll: gesture event (none, click, double click, medium hold, long hold)
//   and the held flag after that poll.
//   cfg_we/cfg_addr/cfg_wdata write the four 20-bit timing registers
//   (debounce, medium hold, long hold, double-click window); write only while
//   no poll is in flight.
// Timing:
//   A poll is captured in an input register, then classified by the state
//   machine and written into the output register, which drives out_valid;
//   a stalled output keeps the poll waiting in the input register. One poll
//   per cycle is sustained while out_stall is low, as the state-update loop
//   (subtract, compare, next phase) is combinational.
// Reset (rst_n low, synchronous): phase idle, times zero, held clear,
//   registers to 50/2000/10000/300 ms, both pipeline stages empty.
// Stall: a stalled output holds its beat; the input register keeps accepting
//   while the output slot is free, then in_stall rises until out_stall drops.
`include "button_gesture_classifier_assert.svh"
module button_gesture_classifier (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bgc_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bgc_pkg::out_beat_t        out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [bgc_pkg::CFG_W-1:0] cfg_wdata
);
  import bgc_pkg::*;

  cfg_t      cfg;
  in_beat_t  s1_data_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_beat_t result;
  out_beat_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  logic      s1_move;
  logic      in_take;

  bgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // the poll in stage 1 is classified when the output slot frees up
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  bgc_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_move),
    .poll   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (s1_move) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BGC_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r && out_stall,
    "input stalled without a blocked stage")
  `BGC_ASSERT_NEXT(a_move_fills_output, s1_move, out_valid_r,
    "classified poll lost before output")
  `BGC_ASSERT_NEXT(a_out_held_while_stalled, out_valid_r && out_stall,
    out_valid_r && $stable(out_data_r),
    "stalled output beat changed")

endmodule

/* test/button_gesture_classifier_tb.sv */
// Self-checking testbench for the button gesture classifier.
module button_gesture_classifier_tb;
  import bgc_pkg::*;

  // Receiver hold-off used to back the pipeline up into the input port.
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  // Cycles without any beat on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 1000;
  // A little margin at the end of the run.
  localparam int unsigned DRAIN_CYCLES = 4;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_beat_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_beat_t       out_data;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Predictor copy of the timing registers and the gesture machine.
  cfg_t timing = '{debounce_ms: 20'd50, medium_hold_ms: 20'd2000,
                   long_hold_ms: 20'd10000, double_click_ms: 20'd300};
  phase_t          phase = PH_IDLE;
  logic [TIME_W-1:0] press_ms = '0;
  logic [TIME_W-1:0] release_ms = '0;
  logic            held = 1'b0;

  // Results predicted for accepted polls, oldest first.
  out_beat_t       pending_gestures[$];

  logic [TIME_W-1:0] now_ms = '0;    // last timestamp sent, or a start point near the wrap
  int unsigned     polls_sent = 0;
  int unsigned     mismatches = 0;
  int unsigned     idle_cycles = 0;
  bit              no_gaps = 1'b0;   // both sides run flat out while set
  bit              hold_off_req = 1'b0;

  button_gesture_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Gesture machine: one poll in, one result out. Elapsed times are plain
  // 32-bit differences, so a wrapped timestamp needs no special handling.
  function automatic out_beat_t classify_poll(input in_beat_t poll);
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_release;
    out_beat_t         res;
    since_press   = poll.time_now - press_ms;
    since_release = poll.time_now - release_ms;
    res.gesture_event = EV_NONE;
    case (phase)
      PH_IDLE: begin
        if (poll.button_level) begin
          press_ms = poll.time_now;
          phase    = PH_PRESSED;
          held     = 1'b1;
        end
      end
      PH_PRESSED: begin
        if (poll.button_level && since_press > timing.long_hold_ms) begin
          // Long hold drops back to idle even though the button is still down.
          res.gesture_event = EV_LONG;
          phase = PH_IDLE;
          held  = 1'b0;
        end else if (poll.button_level && since_press > timing.medium_hold_ms &&
                     since_press < timing.long_hold_ms) begin
          // Repeats on every poll inside the window; empty if medium >= long.
          res.gesture_event = EV_MEDIUM;
        end else if (!poll.button_level && since_press > timing.debounce_ms) begin
          release_ms = poll.time_now;
          phase      = PH_REL_WAIT;
          held       = 1'b0;
        end
      end
      PH_REL_WAIT: begin
        if (poll.button_level && since_release < timing.double_click_ms) begin
          phase = PH_SECOND;
          held  = 1'b1;
        end else if (since_release >= timing.double_click_ms) begin
          res.gesture_event = EV_CLICK;
          phase = PH_IDLE;
        end
      end
      default: begin
        // Second release is debounced against the first press time.
        if (!poll.button_level && since_press > timing.debounce_ms) begin
          res.gesture_event = EV_DOUBLE;
          phase = PH_IDLE;
          held  = 1'b0;
        end
      end
    endcase
    res.held_flag = held;
    return res;
  endfunction

  // Threshold probe: exactly on it, one either side, or anywhere up to twice it plus two.
  function automatic logic [TIME_W-1:0] around(input logic [TIME_W-1:0] v);
    case ($urandom_range(0, 3))
      0:       return v;
      1:       return v + 1;
      2:       return (v == 0) ? v : v - 1;
      default: return $urandom_range(0, 2 * v + 2);
    endcase
  endfunction

  // Offer one poll after a random gap; stays here until the beat is taken.
  task automatic send_poll(input logic level, input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    in_beat_t    beat;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    beat.button_level = level;
    beat.time_now     = stamp;
    now_ms = stamp;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_gestures.push_back(classify_poll(beat));
    polls_sent++;
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic finish_in_flight();
    in_valid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One register write; cfg_we is handled by the caller.
  task automatic put_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE: timing.debounce_ms     = val;
      CFG_MEDIUM:   timing.medium_hold_ms  = val;
      CFG_LONG:     timing.long_hold_ms    = val;
      default:      timing.double_click_ms = val;
    endcase
  endtask

  task automatic apply_timing(input logic [CFG_W-1:0] dbn_v, med_v, lng_v, win_v);
    finish_in_flight();
    cfg_we <= 1'b1;
    put_reg(CFG_LONG, lng_v);
    put_reg(CFG_DEBOUNCE, dbn_v);
    put_reg(CFG_DOUBLE, win_v);
    put_reg(CFG_MEDIUM, med_v);
    cfg_we <= 1'b0;
  endtask

  // One gesture with random content: press, hold around a threshold,
  // release, then wait around the double-click window. Some are pure noise.
  task automatic gesture_sequence();
    int unsigned       kind;
    int unsigned       n;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] rel;
    span = timing.debounce_ms + timing.medium_hold_ms + timing.long_hold_ms +
           timing.double_click_ms + 16;
    kind = $urandom_range(0, 5);
    if ($urandom_range(0, 7) == 0)
      now_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * span);
    if (kind == 5) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0)
          send_poll(1'($urandom_range(0, 1)), $urandom());
        else
          send_poll(1'($urandom_range(0, 1)), now_ms + $urandom_range(0, span));
      end
      return;
    end
    case (kind)
      0, 1:    hold = timing.debounce_ms;
      2:       hold = timing.medium_hold_ms;
      3:       hold = timing.long_hold_ms;
      default: hold = $urandom_range(0, span);
    endcase
    t0 = now_ms + $urandom_range(1, 40);
    send_poll(1'b1, t0);
    n = $urandom_range(0, 3);
    for (int unsigned i = 1; i <= n; i++)
      send_poll(1'b1, t0 + hold * i / (n + 1));
    send_poll(1'b1, t0 + around(hold));
    if (kind == 2 || kind == 3) begin
      // Past the threshold: medium repeats here, long restarts a press.
      repeat ($urandom_range(1, 3)) send_poll(1'b1, now_ms + $urandom_range(1, 3));
    end
    rel = now_ms + timing.debounce_ms + $urandom_range(1, 4);
    send_poll(1'b0, rel);
    if (kind == 1) begin
      send_poll(1'b1, rel + around(timing.double_click_ms));
      send_poll(1'b1, now_ms + $urandom_range(0, 2));
      send_poll(1'b0, now_ms + $urandom_range(0, 3));
    end
    send_poll(1'b0, now_ms + around(timing.double_click_ms));
    send_poll(1'b0, now_ms + timing.double_click_ms + 1);
  endtask

  task automatic run_gesture_mix(input int unsigned count);
    int unsigned start;
    start = polls_sent;
    while (polls_sent - start < count) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      gesture_sequence();
    end
    no_gaps = 1'b0;
  endtask

  // Hand-picked polls at reset timing (50/2000/10000/300).
  task automatic test_directed();
    send_poll(1'b0, 32'h0000_0000);      // idle, released: nothing
    send_poll(1'b1, 32'd100);            // press
    send_poll(1'b1, 32'd130);
    send_poll(1'b0, 32'd140);            // inside debounce: still pressed
    send_poll(1'b0, 32'd200);            // release counts
    send_poll(1'b0, 32'd499);            // one short of the window
    send_poll(1'b0, 32'd500);            // window expired: click
    send_poll(1'b1, 32'd1000);
    send_poll(1'b0, 32'd1100);
    send_poll(1'b1, 32'd1200);           // second press inside the window
    send_poll(1'b0, 32'd1201);           // debounced from first press: double
    send_poll(1'b1, 32'hFFFF_FF00);      // press just before the wrap
    send_poll(1'b1, 32'h0000_0800);      // wrapped hold past medium
    send_poll(1'b1, 32'h0000_0801);      // medium again
    send_poll(1'b1, 32'h0000_2800);      // past long: long hold, back to idle
    send_poll(1'b1, 32'h0000_2801);      // still down: a new press starts
    send_poll(1'b0, 32'hFFFF_FFFF);      // release at the top of the range
    send_poll(1'b0, 32'h0000_0200);      // wrapped wait: click
  endtask

  // Register corners, including the ones that switch events off.
  task automatic test_timing_corners();
    apply_timing(20'd4, 20'd30, 20'd80, 20'd12);
    run_gesture_mix(250);
    apply_timing('0, '0, '0, '0);
    run_gesture_mix(200);
    apply_timing('1, '1, '1, '1);
    run_gesture_mix(200);
    apply_timing(20'd10, 20'd90, 20'd40, 20'd20);  // medium above long
    run_gesture_mix(200);
    apply_timing(20'd50, 20'd2000, 20'd10000, 20'd300);
    run_gesture_mix(250);
  endtask

  task automatic test_random_timing();
    repeat (3) begin
      apply_timing(CFG_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 19)),
                   CFG_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 19)),
                   CFG_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 19)),
                   CFG_W'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 19)));
      run_gesture_mix(200);
    end
  endtask

  // Receiver sits out a long stretch while polls keep coming back to back.
  task automatic test_output_hold_off();
    int unsigned start;
    apply_timing(20'd3, 20'd20, 20'd50, 20'd10);
    hold_off_req = 1'b1;
    no_gaps      = 1'b1;
    start = polls_sent;
    while (polls_sent - start < 60) gesture_sequence();
    no_gaps = 1'b0;
  endtask

  // Result side: random stall per beat, then compare with the oldest
  // prediction field by field.
  initial begin : result_sink
    int unsigned wait_cycles;
    out_beat_t   want;
    out_beat_t   got;
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 5);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
      got = out_data;
      if (pending_gestures.size() == 0) begin
        $error("result beat with no poll outstanding");
        mismatches++;
      end else begin
        want = pending_gestures.pop_front();
        if (got.gesture_event !== want.gesture_event) begin
          $error("gesture_event: expected %0d, got %0d",
                 want.gesture_event, got.gesture_event);
          mismatches++;
        end
        if (got.held_flag !== want.held_flag) begin
          $error("held_flag: expected %0d, got %0d", want.held_flag, got.held_flag);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: any beat on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) === 1'b1 || (out_valid && !out_stall) === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_timing_corners();
    test_random_timing();
    test_output_hold_off();
    finish_in_flight();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
